// ===== sv/tph_pkg.sv =====
// Package for the trace context header parser.
// Holds position and character constants, status and field codes, and the decode and result structs.
// No dependencies.
`default_nettype none

package tph_pkg;

  // Position counter width and header layout
  localparam int unsigned PosW = 6;
  localparam logic [PosW-1:0] HdrLast      = 6'd54;
  localparam logic [PosW-1:0] HdrLen       = 6'd55;
  localparam logic [PosW-1:0] PosSat       = 6'd56;
  localparam logic [PosW-1:0] DashA        = 6'd2;
  localparam logic [PosW-1:0] DashB        = 6'd35;
  localparam logic [PosW-1:0] DashC        = 6'd52;
  localparam logic [PosW-1:0] TraceLoFirst = 6'd19;

  // ASCII codes
  localparam logic [7:0] CharDash = 8'h2d;
  localparam logic [7:0] Char0    = 8'h30;
  localparam logic [7:0] Char9    = 8'h39;
  localparam logic [7:0] CharA    = 8'h61;
  localparam logic [7:0] CharF    = 8'h66;
  localparam logic [7:0] HexAOffs = 8'h57;  // 'a' - 10

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_FORM = 3'd1,
    ST_BAD_VER  = 3'd2,
    ST_BAD_HEX  = 3'd3,
    ST_ZERO_ID  = 3'd4
  } status_t;

  // Which part of the header a character position belongs to
  typedef enum logic [2:0] {
    FLD_NONE,
    FLD_VERSION,
    FLD_DASH,
    FLD_TRACE_HI,
    FLD_TRACE_LO,
    FLD_SPAN,
    FLD_FLAGS
  } field_t;

  typedef struct packed {
    field_t     field;
    logic       form_err;
    logic       ver_err;
    logic       hex_err;
    logic [3:0] digit;
  } char_dec_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] trace_hi;
    logic [63:0] trace_lo;
    logic [63:0] span;
    logic [7:0]  flags;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/tph_char_decode.sv =====
// Character classifier: maps a position and a byte to field, errors and hex digit.
// Depends on tph_pkg.
`default_nettype none

module tph_char_decode (
  input  wire logic [tph_pkg::PosW-1:0] pos,
  input  wire logic [7:0]               char_code,
  output tph_pkg::char_dec_t            dec
);

  logic       is_dec;
  logic       is_hex_alpha;
  logic [7:0] dec_val;
  logic [7:0] alpha_val;

  assign is_dec       = (char_code >= tph_pkg::Char0) && (char_code <= tph_pkg::Char9);
  assign is_hex_alpha = (char_code >= tph_pkg::CharA) && (char_code <= tph_pkg::CharF);
  assign dec_val      = char_code - tph_pkg::Char0;
  assign alpha_val    = char_code - tph_pkg::HexAOffs;

  always_comb begin
    dec = '{field: tph_pkg::FLD_NONE, form_err: 1'b0, ver_err: 1'b0,
            hex_err: 1'b0, digit: 4'd0};
    if (pos >= tph_pkg::HdrLen) begin
      dec.field = tph_pkg::FLD_NONE;
    end else if (pos == tph_pkg::DashA || pos == tph_pkg::DashB || pos == tph_pkg::DashC) begin
      dec.field    = tph_pkg::FLD_DASH;
      dec.form_err = (char_code != tph_pkg::CharDash);
    end else if (pos < tph_pkg::DashA) begin
      dec.field   = tph_pkg::FLD_VERSION;
      dec.ver_err = (char_code != tph_pkg::Char0);
    end else begin
      // Non-hex shifts in a zero digit
      if (is_dec) begin
        dec.digit = dec_val[3:0];
      end else if (is_hex_alpha) begin
        dec.digit = alpha_val[3:0];
      end else begin
        dec.hex_err = 1'b1;
      end
      if (pos < tph_pkg::TraceLoFirst) begin
        dec.field = tph_pkg::FLD_TRACE_HI;
      end else if (pos < tph_pkg::DashB) begin
        dec.field = tph_pkg::FLD_TRACE_LO;
      end else if (pos < tph_pkg::DashC) begin
        dec.field = tph_pkg::FLD_SPAN;
      end else begin
        dec.field = tph_pkg::FLD_FLAGS;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tph_header_state.sv =====
// Per-header state: position counter, hex accumulators, error flags and result.
// Depends on tph_pkg and tph_char_decode.
`default_nettype none

module tph_header_state (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] char_code,
  input  wire logic       last,
  output tph_pkg::result_t res
);

  logic [tph_pkg::PosW-1:0] pos;
  logic [tph_pkg::PosW-1:0] pos_next;
  logic [63:0] trace_hi, trace_hi_next;
  logic [63:0] trace_lo, trace_lo_next;
  logic [63:0] span, span_next;
  logic [7:0]  flags, flags_next;
  logic form_err, form_err_next;
  logic ver_err, ver_err_next;
  logic hex_err, hex_err_next;
  tph_pkg::char_dec_t dec;

  tph_char_decode u_dec (
    .pos       (pos),
    .char_code (char_code),
    .dec       (dec)
  );

  always_comb begin
    pos_next      = (pos == tph_pkg::PosSat) ? pos : pos + 1'b1;
    trace_hi_next = trace_hi;
    trace_lo_next = trace_lo;
    span_next     = span;
    flags_next    = flags;
    form_err_next = form_err | dec.form_err;
    ver_err_next  = ver_err | dec.ver_err;
    hex_err_next  = hex_err | dec.hex_err;
    case (dec.field)
      tph_pkg::FLD_TRACE_HI: trace_hi_next = {trace_hi[59:0], dec.digit};
      tph_pkg::FLD_TRACE_LO: trace_lo_next = {trace_lo[59:0], dec.digit};
      tph_pkg::FLD_SPAN:     span_next     = {span[59:0], dec.digit};
      tph_pkg::FLD_FLAGS:    flags_next    = {flags[3:0], dec.digit};
      default: ;
    endcase
  end

  // Status from the state including this character; length checks the old position
  always_comb begin
    res = '{status: tph_pkg::ST_OK, trace_hi: 64'd0, trace_lo: 64'd0,
            span: 64'd0, flags: 8'd0};
    if (form_err_next || pos != tph_pkg::HdrLast) begin
      res.status = tph_pkg::ST_BAD_FORM;
    end else if (ver_err_next) begin
      res.status = tph_pkg::ST_BAD_VER;
    end else if (hex_err_next) begin
      res.status = tph_pkg::ST_BAD_HEX;
    end else if ((trace_hi_next == 64'd0 && trace_lo_next == 64'd0) || span_next == 64'd0) begin
      res.status = tph_pkg::ST_ZERO_ID;
    end else begin
      res.status   = tph_pkg::ST_OK;
      res.trace_hi = trace_hi_next;
      res.trace_lo = trace_lo_next;
      res.span     = span_next;
      res.flags    = flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      pos      <= '0;
      trace_hi <= '0;
      trace_lo <= '0;
      span     <= '0;
      flags    <= '0;
      form_err <= 1'b0;
      ver_err  <= 1'b0;
      hex_err  <= 1'b0;
    end else if (step) begin
      pos      <= pos_next;
      trace_hi <= trace_hi_next;
      trace_lo <= trace_lo_next;
      span     <= span_next;
      flags    <= flags_next;
      form_err <= form_err_next;
      ver_err  <= ver_err_next;
      hex_err  <= hex_err_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/traceparent_header_parser.sv =====
// Trace context header parser, top level: input register, header state, result register.
// Throughput: one character beat per cycle, sustained, also across header boundaries
// as long as the result register is taken when a header ends.
// Order: a header's last beat is loaded into the input register when accepted, and its
// result is loaded into the result register when that beat advances, then offered.
// Reset (rst, synchronous): empties both registers and clears all per-header state.
// Depends on tph_pkg and tph_header_state.
`default_nettype none

module traceparent_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // character channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_code,
  input  wire logic        end_of_header,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [63:0]      trace_id_high,
  output logic [63:0]      trace_id_low,
  output logic [63:0]      span_id,
  output logic [7:0]       trace_flags
);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;

  logic out_free;
  logic step;
  tph_pkg::result_t res;
  tph_pkg::result_t out_res;

  // A mid-header beat always advances; a last beat needs room in the result register.
  // The result register frees in the same cycle it is taken, so no bubble appears.
  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Hold the payload until the beat advances
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char <= char_code;
      s1_last <= end_of_header;
    end
  end

  tph_header_state u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (s1_char),
    .last      (s1_last),
    .res       (res)
  );

  // Result register: load on the last beat of a header, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last) begin
      out_res <= res;
    end
  end

  assign status        = out_res.status;
  assign trace_id_high = out_res.trace_hi;
  assign trace_id_low  = out_res.trace_lo;
  assign span_id       = out_res.span;
  assign trace_flags   = out_res.flags;

endmodule

`default_nettype wire

// ===== tb/sv/traceparent_header_parser_test.sv =====
`timescale 1ns / 1ps
// Testbench for traceparent_header_parser: random and directed headers,
// one character per beat, checked against an in-bench header predictor.
// Depends on tph_pkg and the parser RTL.

module traceparent_header_parser_test;

  localparam int HoldOffCycles = 300;   // long receiver hold-off, fills the block
  localparam int StallLimit    = 2000;  // cycles with no beat on either side
  localparam int CharBudget    = 1550;  // stop random headers after this many beats

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerG = 8'h67;

  // Predicts the result of each header from the accepted character beats and
  // holds the results still owed by the block.
  class header_result_predictor;
    logic [5:0]  char_pos;
    logic [63:0] trace_hi_acc;
    logic [63:0] trace_lo_acc;
    logic [63:0] span_acc;
    logic [7:0]  flags_acc;
    bit          form_bad;
    bit          version_bad;
    bit          hex_bad;
    tph_pkg::result_t pending_results[$];
    int          mismatch_count;

    function new();
      clear_header();
      mismatch_count = 0;
    endfunction

    function void clear_header();
      char_pos     = '0;
      trace_hi_acc = '0;
      trace_lo_acc = '0;
      span_acc     = '0;
      flags_acc    = '0;
      form_bad     = 1'b0;
      version_bad  = 1'b0;
      hex_bad      = 1'b0;
    endfunction

    // Advance the header state by one accepted character.
    function void note_char(input logic [7:0] c, input logic last);
      logic [5:0] pos;
      logic [7:0] diff;
      logic [3:0] nib;
      tph_pkg::result_t res;
      pos = char_pos;
      if (pos < tph_pkg::HdrLen) begin
        if (pos == tph_pkg::DashA || pos == tph_pkg::DashB || pos == tph_pkg::DashC) begin
          if (c != tph_pkg::CharDash) form_bad = 1'b1;
        end else if (pos < tph_pkg::DashA) begin
          if (c != tph_pkg::Char0) version_bad = 1'b1;
        end else begin
          // non-hex characters shift in a zero digit
          nib = 4'd0;
          if (c >= tph_pkg::Char0 && c <= tph_pkg::Char9) begin
            diff = c - tph_pkg::Char0;
            nib  = diff[3:0];
          end else if (c >= tph_pkg::CharA && c <= tph_pkg::CharF) begin
            diff = c - tph_pkg::CharA + 8'd10;
            nib  = diff[3:0];
          end else begin
            hex_bad = 1'b1;
          end
          if (pos < tph_pkg::TraceLoFirst) trace_hi_acc = {trace_hi_acc[59:0], nib};
          else if (pos < tph_pkg::DashB) trace_lo_acc = {trace_lo_acc[59:0], nib};
          else if (pos < tph_pkg::DashC) span_acc = {span_acc[59:0], nib};
          else flags_acc = {flags_acc[3:0], nib};
        end
      end
      // saturate so that long headers stay flagged
      if (char_pos != tph_pkg::PosSat) char_pos = char_pos + 6'd1;

      if (last) begin
        res = '0;
        if (form_bad || pos != tph_pkg::HdrLast) res.status = tph_pkg::ST_BAD_FORM;
        else if (version_bad) res.status = tph_pkg::ST_BAD_VER;
        else if (hex_bad) res.status = tph_pkg::ST_BAD_HEX;
        else if ((trace_hi_acc == 64'd0 && trace_lo_acc == 64'd0) || span_acc == 64'd0)
          res.status = tph_pkg::ST_ZERO_ID;
        else res.status = tph_pkg::ST_OK;
        if (res.status == tph_pkg::ST_OK) begin
          res.trace_hi = trace_hi_acc;
          res.trace_lo = trace_lo_acc;
          res.span     = span_acc;
          res.flags    = flags_acc;
        end
        pending_results = {pending_results, res};
        clear_header();
      end
    endfunction

    // Compare one accepted result beat with the oldest pending result.
    function void check_result(input logic [2:0] got_status, input logic [63:0] got_hi,
                               input logic [63:0] got_lo, input logic [63:0] got_span,
                               input logic [7:0] got_flags);
      tph_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with no header pending, status %0d", $time, got_status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got_status);
          mismatch_count++;
        end
        if (got_hi !== want.trace_hi) begin
          $display("%0t: trace_id_high expected %h got %h", $time, want.trace_hi, got_hi);
          mismatch_count++;
        end
        if (got_lo !== want.trace_lo) begin
          $display("%0t: trace_id_low expected %h got %h", $time, want.trace_lo, got_lo);
          mismatch_count++;
        end
        if (got_span !== want.span) begin
          $display("%0t: span_id expected %h got %h", $time, want.span, got_span);
          mismatch_count++;
        end
        if (got_flags !== want.flags) begin
          $display("%0t: trace_flags expected %h got %h", $time, want.flags, got_flags);
          mismatch_count++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = 8'h00;
  logic        end_of_header = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [63:0] trace_id_high;
  logic [63:0] trace_id_low;
  logic [63:0] span_id;
  logic [7:0]  trace_flags;

  header_result_predictor predictor;
  logic [7:0] header_chars[$];     // header under construction, one byte per beat
  int         chars_sent = 0;
  int         headers_sent = 0;
  int         idle_cycles = 0;
  bit         hold_off_pending = 1'b0;

  traceparent_header_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .end_of_header (end_of_header),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .trace_id_high (trace_id_high),
    .trace_id_low  (trace_id_low),
    .span_id       (span_id),
    .trace_flags   (trace_flags)
  );

  always #6 clk = ~clk;

  // Idle length shared by sender and receiver: mostly none, some short, a few long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 93) return $urandom_range(1, 3);
    else return $urandom_range(10, 40);
  endfunction

  // Append one byte to the header under construction.
  function automatic void add_char(input logic [7:0] c);
    header_chars = {header_chars, c};
  endfunction

  // Append a value as lowercase hex digits, most significant first.
  function automatic void push_hex(input logic [63:0] value, input int digits);
    logic [3:0] nib;
    for (int i = digits - 1; i >= 0; i--) begin
      nib = value[4*i +: 4];
      add_char(nib < 4'd10 ? tph_pkg::Char0 + {4'd0, nib}
                           : tph_pkg::CharA + {4'd0, nib} - 8'd10);
    end
  endfunction

  // Build a well-formed version 00 header from its fields.
  function automatic void build_header(input logic [63:0] hi, input logic [63:0] lo,
                                       input logic [63:0] sp, input logic [7:0] fl);
    header_chars.delete();
    add_char(tph_pkg::Char0);
    add_char(tph_pkg::Char0);
    add_char(tph_pkg::CharDash);
    push_hex(hi, 16);
    push_hex(lo, 16);
    add_char(tph_pkg::CharDash);
    push_hex(sp, 16);
    add_char(tph_pkg::CharDash);
    push_hex({56'd0, fl}, 2);
  endfunction

  // Offer one character beat; start and end at a falling edge. Drop valid
  // only for an idle gap, so valid is never lowered and raised in one step.
  task automatic send_char(input logic [7:0] c, input logic last, input bit eager);
    int gap;
    gap = eager ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    char_code     <= c;
    end_of_header <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send the built header; mark its last byte. Some headers go back to back.
  task automatic send_header();
    bit eager;
    eager = ($urandom_range(0, 3) == 0);
    foreach (header_chars[i]) begin
      send_char(header_chars[i], i == header_chars.size() - 1, eager);
      chars_sent++;
    end
    headers_sent++;
  endtask

  // Sample both channels at the rising edge and feed the predictor.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predictor.note_char(char_code, end_of_header);
      if (out_valid && out_ready)
        predictor.check_result(status, trace_id_high, trace_id_low, span_id, trace_flags);
    end
  end

  // Abort when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: ready runs alternating with stalls; one long hold-off on request.
  initial begin
    int run;
    int stall;
    while (rst) @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      repeat (run) @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        stall = HoldOffCycles;
      end else begin
        stall = pick_idle();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Stimulus: directed headers, then random headers, then drain and report.
  initial begin
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] sp;
    logic [7:0]  fl;
    int          kind;
    int          pos;
    predictor = new();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // plain valid header
    build_header(64'h0af7651916cd43dd, 64'h8448eb211c80319c, 64'hb7ad6b7169203331, 8'h01);
    send_header();
    // all ones, the top digit everywhere
    build_header('1, '1, '1, 8'hff);
    send_header();
    // upper trace half zero is still a valid id; flags zero
    build_header(64'd0, 64'd1, 64'd1, 8'h00);
    send_header();
    // digits 0..9 and a..f across the fields
    build_header(64'h0123456789abcdef, 64'hfedcba9876543210, 64'h9a8b7c6d5e4f3021, 8'h9a);
    send_header();
    // all-zero trace id
    build_header(64'd0, 64'd0, 64'h1234, 8'h01);
    send_header();
    // all-zero span id
    build_header(64'h55, 64'haa, 64'd0, 8'h01);
    send_header();
    // bad version: hex but not zero in the first place, then in the second
    build_header(64'h1, 64'h2, 64'h3, 8'h01);
    header_chars[0] = tph_pkg::CharF;
    send_header();
    build_header(64'h1, 64'h2, 64'h3, 8'h01);
    header_chars[1] = tph_pkg::Char0 + 8'd1;
    send_header();
    // uppercase digit in the trace id, dash in the span id, top byte in flags plus a zero byte in the trace id
    build_header(64'h1, 64'h2, 64'h3, 8'h01);
    header_chars[10] = CharUpperA;
    send_header();
    build_header(64'h1, 64'h2, 64'h3, 8'h01);
    header_chars[40] = tph_pkg::CharDash;
    send_header();
    build_header(64'h1, 64'h2, 64'h3, 8'h01);
    header_chars[54] = 8'hff;
    header_chars[20] = 8'h00;
    send_header();
    // missing middle dash
    build_header(64'h1, 64'h2, 64'h3, 8'h01);
    header_chars[tph_pkg::DashB] = tph_pkg::Char0;
    send_header();
    // one short, one long, a single byte, and past saturation
    build_header(64'h1, 64'h2, 64'h3, 8'h01);
    void'(header_chars.pop_back());
    send_header();
    build_header(64'h1, 64'h2, 64'h3, 8'h01);
    add_char(tph_pkg::Char0);
    send_header();
    header_chars.delete();
    add_char(tph_pkg::Char0);
    send_header();
    build_header(64'h1, 64'h2, 64'h3, 8'h01);
    repeat (15) add_char(tph_pkg::CharA);
    send_header();
    // the counter must be clear again after a saturated header
    build_header(64'hdead, 64'hbeef, 64'hcafe, 8'h03);
    send_header();
    // precedence: version beats hex beats zero id; form beats version
    build_header(64'd0, 64'd0, 64'h7, 8'h01);
    header_chars[1] = tph_pkg::CharA;
    header_chars[5] = CharLowerG;
    send_header();
    build_header(64'h7, 64'h7, 64'd0, 8'h01);
    header_chars[45] = CharUpperA + 8'd5;
    send_header();
    build_header(64'h7, 64'h7, 64'h7, 8'h01);
    header_chars[tph_pkg::DashC] = tph_pkg::CharA;
    header_chars[0] = tph_pkg::CharDash;
    send_header();

    // Random part: mostly well-formed headers with random content, the rest
    // corrupted, cut short, stretched, or plain noise. Fill the block once
    // with a long receiver hold-off while headers keep coming.
    hold_off_pending = 1'b1;
    while (chars_sent < CharBudget) begin
      hi = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom};
      lo = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom};
      sp = ($urandom_range(0, 11) == 0) ? 64'd0 : {$urandom, $urandom};
      fl = 8'($urandom_range(0, 255));
      build_header(hi, lo, sp, fl);
      kind = $urandom_range(0, 15);
      case (kind)
        0: begin
          header_chars[$urandom_range(0, 54)] = 8'($urandom_range(0, 255));
        end
        1: begin
          // non-hex byte at a digit position
          pos = $urandom_range(3, 54);
          if (pos == tph_pkg::DashB || pos == tph_pkg::DashC) pos = pos + 1;
          case ($urandom_range(0, 3))
            0: header_chars[pos] = CharUpperA + 8'($urandom_range(0, 5));
            1: header_chars[pos] = tph_pkg::CharDash;
            2: header_chars[pos] = CharLowerG + 8'($urandom_range(0, 18));
            default: header_chars[pos] = 8'($urandom_range(128, 255));
          endcase
        end
        2: begin
          header_chars = header_chars[0:$urandom_range(0, 53)];
        end
        3: begin
          repeat ($urandom_range(1, 20)) add_char(8'($urandom_range(0, 255)));
        end
        4: begin
          header_chars[$urandom_range(0, 1)] = 8'($urandom_range(0, 255));
        end
        5: begin
          header_chars.delete();
          repeat ($urandom_range(1, 70)) add_char(8'($urandom_range(0, 255)));
        end
        default: begin
          // keep it well-formed
        end
      endcase
      send_header();
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed result, then keep watching for stray beats.
    while (predictor.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (predictor.mismatch_count == 0 && predictor.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tph_pkg.sv
sv/tph_char_decode.sv
sv/tph_header_state.sv
sv/traceparent_header_parser.sv
tb/sv/traceparent_header_parser_test.sv
